// ===== design/lpip_pkg.sv =====
// ----------------------------------------------------------------------------
// lpip_pkg: shared types and constants of the length prefix item parser
// Result word layout, event and fault codes, header byte boundaries.
// ----------------------------------------------------------------------------
package lpip_pkg;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ERROR   = 2'd2
  } lpip_kind_t;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_SHORT    = 3'd1,
    FLT_NONCANON = 3'd2,
    FLT_OVERFLOW = 3'd3,
    FLT_LEADZERO = 3'd4
  } lpip_fault_t;

  // header byte boundaries
  localparam logic [7:0] HDR_STR_SHORT  = 8'h80;
  localparam logic [7:0] HDR_STR_LONG   = 8'hB8;
  localparam logic [7:0] HDR_LIST_SHORT = 8'hC0;
  localparam logic [7:0] HDR_LIST_LONG  = 8'hF8;
  localparam int unsigned SHORT_MAX_LEN = 55;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    lpip_kind_t  kind;
    logic        is_list;
    logic [31:0] length;
    logic [3:0]  prefix;
    logic [7:0]  payload;
    lpip_fault_t fault;
    logic        last;
  } lpip_event_t;

  // words produced by one accepted byte
  typedef struct packed {
    logic [1:0]  cnt;
    lpip_event_t ev0;
    lpip_event_t ev1;
  } lpip_push_t;

  localparam lpip_event_t EV_ZERO = '{kind: EV_HEADER, is_list: 1'b0, length: 32'd0,
                                      prefix: 4'd0, payload: 8'd0, fault: FLT_NONE,
                                      last: 1'b0};

  function automatic lpip_event_t mk_header(logic lst, logic [31:0] len, logic [3:0] pre);
    lpip_event_t e;
    e         = EV_ZERO;
    e.kind    = EV_HEADER;
    e.is_list = lst;
    e.length  = len;
    e.prefix  = pre;
    return e;
  endfunction

  function automatic lpip_event_t mk_payload(logic [7:0] b);
    lpip_event_t e;
    e         = EV_ZERO;
    e.kind    = EV_PAYLOAD;
    e.payload = b;
    return e;
  endfunction

  function automatic lpip_event_t mk_error(lpip_fault_t f);
    lpip_event_t e;
    e       = EV_ZERO;
    e.kind  = EV_ERROR;
    e.fault = f;
    return e;
  endfunction

endpackage

// ===== design/lpip_ifs.sv =====
// ----------------------------------------------------------------------------
// lpip channel interfaces
// Byte input channel and result word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface lpip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic        item_is_list;
  logic [31:0] item_length;
  logic [3:0]  prefix_length;
  logic [7:0]  payload_byte;
  logic [2:0]  fault_code;
  logic        run_last;

  modport source (output valid, output event_kind, output item_is_list,
                  output item_length, output prefix_length, output payload_byte,
                  output fault_code, output run_last, input ready);
  modport sink   (input valid, input event_kind, input item_is_list,
                  input item_length, input prefix_length, input payload_byte,
                  input fault_code, input run_last, output ready);
endinterface

// ===== design/lpip_decode.sv =====
// ----------------------------------------------------------------------------
// lpip_decode: header decoder and parser state
// Updates the parse state for each accepted byte and forms up to two words.
// ----------------------------------------------------------------------------
module lpip_decode #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                buffer_end,
  output lpip_pkg::lpip_push_t push
);
  import lpip_pkg::*;

  localparam int LB = LENGTH_BITS;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CANON   = 3'd1,
    PH_LEN     = 3'd2,
    PH_LENZ    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DROP    = 3'd5
  } phase_t;

  phase_t          phase_r,    phase_nxt;
  logic            pend_list_r, pend_list_nxt;
  logic [3:0]      len_left_r, len_left_nxt;
  logic [LB-1:0]   acc_r,      acc_nxt;
  logic            acc_ovf_r,  acc_ovf_nxt;
  logic [LB-1:0]   pay_left_r, pay_left_nxt;
  logic [3:0]      pre_cnt_r,  pre_cnt_nxt;
  logic [LB-1:0]   need_r,     need_nxt;

  logic [LB-1:0]   need_dec;
  logic [LB-1:0]   acc_new;
  logic            ovf_new;
  logic [LB+31:0]  acc_wide;
  logic [3:0]      pre_new;
  logic [3:0]      left_new;
  logic [LB-1:0]   pay_new;
  logic [5:0]      slen;
  logic            lead_zero;
  logic            req_en;
  logic [LB-1:0]   req_len;
  lpip_fault_t     fault;
  logic [1:0]      n;
  lpip_event_t     ev0, ev1;

  assign need_dec  = need_r - LB'(need_r != '0);
  assign acc_new   = LB'({acc_r, in_byte});
  assign ovf_new   = acc_ovf_r | (|acc_r[LB-1:LB-8]);
  assign acc_wide  = {32'd0, acc_new};
  assign pre_new   = pre_cnt_r + 4'd1;
  assign left_new  = len_left_r - 4'(len_left_r != 4'd0);
  assign pay_new   = pay_left_r - LB'(pay_left_r != '0);
  assign slen      = in_byte[5:0];
  // zero as the first length byte
  assign lead_zero = (phase_r == PH_LEN) && (pre_cnt_r == 4'd1) && (in_byte == 8'd0);

  always_comb begin
    phase_nxt     = phase_r;
    pend_list_nxt = pend_list_r;
    len_left_nxt  = len_left_r;
    acc_nxt       = acc_r;
    acc_ovf_nxt   = acc_ovf_r;
    pay_left_nxt  = pay_left_r;
    pre_cnt_nxt   = pre_cnt_r;
    need_nxt      = need_dec;
    req_en        = 1'b0;
    req_len       = '0;
    fault         = FLT_NONE;
    n             = 2'd0;
    ev0           = EV_ZERO;
    ev1           = EV_ZERO;

    if (phase_r == PH_DROP) begin
      need_nxt = need_r;
    end else begin
      case (phase_r)
        PH_CANON: begin
          if (in_byte < HDR_STR_SHORT) begin
            fault = FLT_NONCANON;
          end else begin
            ev0          = mk_header(1'b0, 32'd1, 4'd1);
            ev1          = mk_payload(in_byte);
            n            = 2'd2;
            pay_left_nxt = '0;
            phase_nxt    = PH_IDLE;
          end
        end
        PH_LEN, PH_LENZ: begin
          acc_nxt      = acc_new;
          acc_ovf_nxt  = ovf_new;
          pre_cnt_nxt  = pre_new;
          len_left_nxt = left_new;
          if (lead_zero) begin
            phase_nxt = PH_LENZ;
          end
          if (left_new == 4'd0) begin
            if (phase_r == PH_LENZ || lead_zero) begin
              fault = FLT_LEADZERO;
            end else if (!ovf_new && acc_new <= LB'(SHORT_MAX_LEN)) begin
              fault = FLT_NONCANON;
            end else if (ovf_new) begin
              fault = FLT_OVERFLOW;
            end else begin
              ev0     = mk_header(pend_list_r, acc_wide[31:0], pre_new);
              n       = 2'd1;
              req_en  = 1'b1;
              req_len = acc_new;
              if (pend_list_r) begin
                phase_nxt = PH_IDLE;
              end else begin
                pay_left_nxt = acc_new;
                phase_nxt    = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          ev0          = mk_payload(in_byte);
          n            = 2'd1;
          pay_left_nxt = pay_new;
          if (pay_new == '0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          // idle, and codes never entered
          if (in_byte < HDR_STR_SHORT) begin
            ev0 = mk_header(1'b0, 32'd1, 4'd0);
            ev1 = mk_payload(in_byte);
            n   = 2'd2;
          end else if (in_byte < HDR_STR_LONG) begin
            pre_cnt_nxt = 4'd1;
            if (slen == 6'd1) begin
              // 0x81 waits for the next byte to check canonical form
              phase_nxt    = PH_CANON;
              pay_left_nxt = LB'(1);
            end else begin
              ev0     = mk_header(1'b0, {26'd0, slen}, 4'd1);
              n       = 2'd1;
              req_en  = 1'b1;
              req_len = LB'(slen);
              if (slen != 6'd0) begin
                pay_left_nxt = LB'(slen);
                phase_nxt    = PH_PAYLOAD;
              end
            end
          end else if (in_byte < HDR_LIST_SHORT || in_byte >= HDR_LIST_LONG) begin
            pend_list_nxt = (in_byte >= HDR_LIST_LONG);
            len_left_nxt  = {1'b0, in_byte[2:0]} + 4'd1;
            acc_nxt       = '0;
            acc_ovf_nxt   = 1'b0;
            pre_cnt_nxt   = 4'd1;
            phase_nxt     = PH_LEN;
          end else begin
            ev0     = mk_header(1'b1, {26'd0, slen}, 4'd1);
            n       = 2'd1;
            req_en  = 1'b1;
            req_len = LB'(slen);
          end
        end
      endcase

      if (req_en && req_len > need_dec) begin
        need_nxt = req_len;
      end

      if (fault != FLT_NONE) begin
        ev0 = mk_error(fault);
        ev1 = EV_ZERO;
        n   = 2'd1;
      end else if (buffer_end && (phase_nxt != PH_IDLE || need_nxt != '0)) begin
        ev0 = mk_error(FLT_SHORT);
        ev1 = EV_ZERO;
        n   = 2'd1;
      end
    end

    // buffer end or fault clears the parse state
    if (buffer_end || fault != FLT_NONE) begin
      phase_nxt     = (buffer_end || phase_r == PH_DROP) ? PH_IDLE : PH_DROP;
      pend_list_nxt = 1'b0;
      len_left_nxt  = 4'd0;
      acc_nxt       = '0;
      acc_ovf_nxt   = 1'b0;
      pay_left_nxt  = '0;
      pre_cnt_nxt   = 4'd0;
      need_nxt      = '0;
    end
    if (!buffer_end && fault != FLT_NONE) begin
      phase_nxt = PH_DROP;
    end

    ev0.last = (n == 2'd1);
    ev1.last = 1'b1;
  end

  assign push.cnt = accept ? n : 2'd0;
  assign push.ev0 = ev0;
  assign push.ev1 = ev1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_list_r <= 1'b0;
      len_left_r  <= 4'd0;
      acc_r       <= '0;
      acc_ovf_r   <= 1'b0;
      pay_left_r  <= '0;
      pre_cnt_r   <= 4'd0;
      need_r      <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      pend_list_r <= pend_list_nxt;
      len_left_r  <= len_left_nxt;
      acc_r       <= acc_nxt;
      acc_ovf_r   <= acc_ovf_nxt;
      pay_left_r  <= pay_left_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      need_r      <= need_nxt;
    end
  end

endmodule

// ===== design/lpip_queue.sv =====
// ----------------------------------------------------------------------------
// lpip_queue: result word queue
// Takes up to two words per cycle, hands out one word per cycle while head_ready is high.
// ----------------------------------------------------------------------------
module lpip_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpip_pkg::lpip_push_t  push,
  output logic                  space_ok,
  output logic                  head_valid,
  input  logic                  head_ready,
  output lpip_pkg::lpip_event_t head
);
  import lpip_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lpip_event_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr1;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic               pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  // room for the two words a single byte can make
  assign space_ok   = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr1    = wr_ptr_r + PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= push.ev0;
    end
    if (push.cnt == 2'd2) begin
      slot_r[wr_ptr1] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/length_prefix_item_parser_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefix_item_parser_unit: streaming RLP item parser
//
//   channel   dir  handshake           payload
//   in_chan   in   valid/ready         in_byte, buffer_end
//   out_chan  out  valid/ready         event_kind, item_is_list, item_length,
//                                      prefix_length, payload_byte, fault_code,
//                                      run_last
//
// One byte is taken per cycle while the result queue has two free slots.
// Each byte makes zero, one or two words; the result port moves one word per
// cycle while out_chan.ready is high. A byte's first word is written to the
// result queue when the byte is taken and reaches out_chan after older words.
// Reset is synchronous: parser idle, result queue empty.
// A stalled result port fills the four-word queue; in_chan.ready drops once
// three words wait.
// ----------------------------------------------------------------------------
module length_prefix_item_parser_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  lpip_in_if.sink   in_chan,
  lpip_out_if.source out_chan
);
  import lpip_pkg::*;

  lpip_push_t  push;
  lpip_event_t head;
  logic        accept;
  logic        space_ok;

  assign in_chan.ready = space_ok;
  assign accept        = in_chan.valid && space_ok;

  lpip_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_chan.in_byte),
    .buffer_end (in_chan.buffer_end),
    .push       (push)
  );

  lpip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .head_valid (out_chan.valid),
    .head_ready (out_chan.ready),
    .head       (head)
  );

  assign out_chan.event_kind    = head.kind;
  assign out_chan.item_is_list  = head.is_list;
  assign out_chan.item_length   = head.length;
  assign out_chan.prefix_length = head.prefix;
  assign out_chan.payload_byte  = head.payload;
  assign out_chan.fault_code    = head.fault;
  assign out_chan.run_last      = head.last;

endmodule

// ===== sim/rlp_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_event_checker: result checking for the length prefix item parser
// Watches the byte and result channels, runs every accepted byte through its
// own RLP decoder and compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module rlp_event_checker #(
  parameter int LENGTH_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  lpip_in_if   in_mon,
  lpip_out_if  out_mon,
  output int   mismatches,
  output int   words_pending
);
  import lpip_pkg::*;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_CANON,
    PS_LEN,
    PS_LENZ,
    PS_PAYLOAD,
    PS_DROP
  } parse_state_t;

  parse_state_t ps;
  logic         list_pending;
  logic [3:0]   len_bytes_left;
  logic [63:0]  len_acc;
  logic [63:0]  payload_left;
  logic [3:0]   hdr_count;
  logic [63:0]  bytes_owed;  // bytes the buffer still has to hold

  lpip_event_t step_events[$];
  lpip_event_t expected_events[$];

  function automatic void clear_parser();
    ps             = PS_IDLE;
    list_pending   = 1'b0;
    len_bytes_left = '0;
    len_acc        = '0;
    payload_left   = '0;
    hdr_count      = '0;
    bytes_owed     = '0;
  endfunction

  function automatic void add_event(lpip_kind_t k, logic lst, logic [63:0] len,
                                    logic [3:0] pre, logic [7:0] pay, lpip_fault_t f);
    lpip_event_t e;
    e         = '0;
    e.kind    = k;
    e.is_list = lst;
    e.length  = len[31:0];
    e.prefix  = pre;
    e.payload = pay;
    e.fault   = f;
    step_events.push_back(e);
  endfunction

  function automatic void owe(logic [63:0] len);
    if (len > bytes_owed) bytes_owed = len;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    lpip_fault_t flt;
    logic [63:0] len;
    flt = FLT_NONE;
    step_events.delete();
    if (ps == PS_DROP) begin
      if (fin) clear_parser();
      return;
    end
    if (bytes_owed != 0) bytes_owed--;
    case (ps)
      PS_IDLE: begin
        if (b < HDR_STR_SHORT) begin
          add_event(EV_HEADER, 1'b0, 64'd1, 4'd0, 8'd0, FLT_NONE);
          add_event(EV_PAYLOAD, 1'b0, 64'd0, 4'd0, b, FLT_NONE);
        end else if (b < HDR_STR_LONG) begin
          len       = 64'(b - HDR_STR_SHORT);
          hdr_count = 4'd1;
          // one-byte string header waits for the byte to judge canonical form
          if (len == 1) begin
            ps           = PS_CANON;
            payload_left = 64'd1;
          end else begin
            add_event(EV_HEADER, 1'b0, len, 4'd1, 8'd0, FLT_NONE);
            owe(len);
            if (len != 0) begin
              payload_left = len;
              ps           = PS_PAYLOAD;
            end
          end
        end else if (b < HDR_LIST_SHORT || b >= HDR_LIST_LONG) begin
          list_pending   = (b >= HDR_LIST_LONG);
          len_bytes_left = list_pending ? 4'(b - (HDR_LIST_LONG - 8'd1))
                                        : 4'(b - (HDR_STR_LONG - 8'd1));
          len_acc        = '0;
          hdr_count      = 4'd1;
          ps             = PS_LEN;
        end else begin
          len = 64'(b - HDR_LIST_SHORT);
          add_event(EV_HEADER, 1'b1, len, 4'd1, 8'd0, FLT_NONE);
          owe(len);
        end
      end
      PS_CANON: begin
        if (b < HDR_STR_SHORT) begin
          flt = FLT_NONCANON;
        end else begin
          add_event(EV_HEADER, 1'b0, 64'd1, 4'd1, 8'd0, FLT_NONE);
          add_event(EV_PAYLOAD, 1'b0, 64'd0, 4'd0, b, FLT_NONE);
          payload_left = '0;
          ps           = PS_IDLE;
        end
      end
      PS_LEN, PS_LENZ: begin
        if (ps == PS_LEN && hdr_count == 4'd1 && b == 8'd0) ps = PS_LENZ;
        len_acc   = {len_acc[55:0], b};
        hdr_count = hdr_count + 4'd1;
        if (len_bytes_left != 0) len_bytes_left--;
        if (len_bytes_left == 0) begin
          // priority: leading zero, then short length, then too wide
          if (ps == PS_LENZ) begin
            flt = FLT_LEADZERO;
          end else if (len_acc <= SHORT_MAX_LEN) begin
            flt = FLT_NONCANON;
          end else if ((len_acc >> LENGTH_BITS) != 0) begin
            flt = FLT_OVERFLOW;
          end else begin
            add_event(EV_HEADER, list_pending, len_acc, hdr_count, 8'd0, FLT_NONE);
            owe(len_acc);
            if (list_pending) begin
              ps = PS_IDLE;
            end else begin
              payload_left = len_acc;
              ps           = PS_PAYLOAD;
            end
          end
        end
      end
      default: begin
        add_event(EV_PAYLOAD, 1'b0, 64'd0, 4'd0, b, FLT_NONE);
        if (payload_left != 0) payload_left--;
        if (payload_left == 0) ps = PS_IDLE;
      end
    endcase

    if (flt != FLT_NONE) begin
      step_events.delete();
      add_event(EV_ERROR, 1'b0, 64'd0, 4'd0, 8'd0, flt);
      clear_parser();
      if (!fin) ps = PS_DROP;
    end else if (fin) begin
      // buffer ends with an item still open
      if (ps != PS_IDLE || bytes_owed != 0) begin
        step_events.delete();
        add_event(EV_ERROR, 1'b0, 64'd0, 4'd0, 8'd0, FLT_SHORT);
      end
      clear_parser();
    end

    if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lpip_event_t want;
    if (!rst_n) begin
      clear_parser();
      expected_events.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.in_byte, in_mon.buffer_end);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got kind %0d fault %0d",
                   $time, out_mon.event_kind, out_mon.fault_code);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(out_mon.event_kind));
          check_field("item_is_list", 32'(want.is_list), 32'(out_mon.item_is_list));
          check_field("item_length", want.length, out_mon.item_length);
          check_field("prefix_length", 32'(want.prefix), 32'(out_mon.prefix_length));
          check_field("payload_byte", 32'(want.payload), 32'(out_mon.payload_byte));
          check_field("fault_code", 32'(want.fault), 32'(out_mon.fault_code));
          check_field("run_last", 32'(want.last), 32'(out_mon.run_last));
        end
      end
    end
    words_pending <= expected_events.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: length prefix item parser
// Feeds directed header corner cases, then random RLP buffers (well formed,
// nested, truncated, malformed and noise) with bursty input and a stalling
// result port; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import lpip_pkg::*;

  localparam int LENGTH_BITS  = 32;
  localparam int ITEM_TARGET  = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 400;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst_n;
  int   bytes_sent;
  int   burst_left;
  int   cycle_count;
  int   mismatches;
  int   words_pending;

  lpip_in_if  in_ch ();
  lpip_out_if out_ch ();

  length_prefix_item_parser_unit #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  rlp_event_checker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // string lengths: mostly tiny, some long form, rarely a two-byte length
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 1;
    if (r < 92) return $urandom_range(0, 6);
    if (r < 99) return $urandom_range(56, 60);
    return $urandom_range(256, 260);
  endfunction

  task automatic put_header(ref logic [7:0] q[$], input logic is_list,
                            input int unsigned len);
    logic [7:0]  size_be[$];
    int unsigned rest;
    if (len <= SHORT_MAX_LEN) begin
      q.push_back((is_list ? HDR_LIST_SHORT : HDR_STR_SHORT) + 8'(len));
    end else begin
      rest = len;
      while (rest != 0) begin
        size_be.push_front(8'(rest));
        rest = rest >> 8;
      end
      q.push_back((is_list ? HDR_LIST_LONG : HDR_STR_LONG) - 8'd1 + 8'(size_be.size()));
      foreach (size_be[i]) q.push_back(size_be[i]);
    end
  endtask

  task automatic put_string(ref logic [7:0] q[$], input int unsigned len);
    logic [7:0] v;
    if (len == 1) begin
      v = 8'($urandom);
      if (v >= HDR_STR_SHORT) q.push_back(HDR_STR_SHORT + 8'd1);
      q.push_back(v);
    end else begin
      put_header(q, 1'b0, len);
      repeat (len) q.push_back(8'($urandom));
    end
  endtask

  task automatic put_flat_list(ref logic [7:0] q[$], input int unsigned count);
    logic [7:0] body[$];
    repeat (count) put_string(body, pick_len());
    put_header(q, 1'b1, body.size());
    foreach (body[i]) q.push_back(body[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.buffer_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // result port: stall patterns in segments, plus one long hold-off
  initial begin
    int seg_len;
    int mode;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && bytes_sent >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seg_len = $urandom_range(10, 80);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [8:0] directed[$];
    logic [7:0] frame[$];
    logic [7:0] nest[$];
    int         n;
    bit         drained;

    // {buffer_end, byte}
    directed = '{
      {1'b1, 8'h00}, {1'b1, 8'h7F},                       // literal extremes
      {1'b1, 8'h80},                                      // empty string
      {1'b0, 8'h81}, {1'b1, 8'h80},                       // one-byte string
      {1'b0, 8'h81}, {1'b1, 8'h05},                       // one-byte string, non-canonical
      {1'b0, 8'hB8}, {1'b1, 8'h37},                       // long form with length 55
      {1'b0, 8'hB9}, {1'b0, 8'h00}, {1'b1, 8'h40},        // leading zero
      {1'b0, 8'hBC}, {1'b0, 8'h01}, {1'b0, 8'h00},
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},        // length too wide
      {1'b1, 8'hC0},                                      // empty list
      {1'b1, 8'hF7},                                      // list cut short
      {1'b0, 8'h82}, {1'b1, 8'hAA},                       // string cut short
      {1'b0, 8'h81}, {1'b0, 8'h05}, {1'b1, 8'h11}         // fault, then dropped byte
    };

    bytes_sent       = 0;
    burst_left       = 0;
    drained          = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= 8'd0;
    in_ch.buffer_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    while (bytes_sent < ITEM_TARGET) begin
      if (!drained && bytes_sent >= ITEM_TARGET / 2) begin
        drained = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
      end

      frame.delete();
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 5))
          0, 1, 2: put_string(frame, pick_len());
          3: put_flat_list(frame, ($urandom_range(0, 11) == 0) ? $urandom_range(12, 20)
                                                               : $urandom_range(0, 4));
          default: begin
            // list holding strings and inner lists
            nest.delete();
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 1) == 1) put_flat_list(nest, $urandom_range(0, 3));
              else put_string(nest, pick_len());
            end
            put_header(frame, 1'b1, nest.size());
            foreach (nest[i]) frame.push_back(nest[i]);
          end
        endcase
      end

      case ($urandom_range(0, 19))
        13, 14: begin
          if (frame.size() > 1) frame = frame[0:$urandom_range(0, frame.size() - 2)];
        end
        15, 16: begin
          // malformed header after the good items, maybe followed by junk
          case ($urandom_range(0, 4))
            0: begin
              frame.push_back(HDR_STR_SHORT + 8'd1);
              frame.push_back(8'($urandom_range(0, 127)));
            end
            1: begin
              frame.push_back(HDR_STR_LONG);
              frame.push_back(8'($urandom_range(0, SHORT_MAX_LEN)));
            end
            2: begin
              frame.push_back(HDR_LIST_LONG);
              frame.push_back(8'($urandom_range(0, SHORT_MAX_LEN)));
            end
            3: begin
              n = $urandom_range(2, 8);
              frame.push_back(HDR_STR_LONG - 8'd1 + 8'(n));
              frame.push_back(8'd0);
              repeat (n - 1) frame.push_back(8'($urandom));
            end
            default: begin
              n = $urandom_range(5, 8);
              frame.push_back(($urandom_range(0, 1) == 1 ? HDR_LIST_LONG : HDR_STR_LONG)
                              - 8'd1 + 8'(n));
              frame.push_back(8'($urandom_range(1, 255)));
              repeat (n - 1) frame.push_back(8'($urandom));
            end
          endcase
          repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        end
        17: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        18, 19: begin
          frame.delete();
          repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
        end
        default: ;
      endcase

      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== length_prefix_item_parser_unit.f =====
design/lpip_pkg.sv
design/lpip_ifs.sv
design/lpip_decode.sv
design/lpip_queue.sv
design/length_prefix_item_parser_unit.sv
sim/rlp_event_checker.sv
sim/testbench.sv
